>>> design/windowed_brightness_dark_decision_assert.svh
// Assertion macros for the windowed brightness dark decision block.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef WINDOWED_BRIGHTNESS_DARK_DECISION_ASSERT_SVH
`define WINDOWED_BRIGHTNESS_DARK_DECISION_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define WBDD_ASSERT_IMPLY(lbl, cond, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error("windowed_brightness_dark_decision: same-cycle check failed");

// Next-cycle implication.
`define WBDD_ASSERT_NEXT(lbl, cond, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error("windowed_brightness_dark_decision: next-cycle check failed");

`else

`define WBDD_ASSERT_IMPLY(lbl, cond, expr)
`define WBDD_ASSERT_NEXT(lbl, cond, expr)

`endif

`endif

>>> design/wbdd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the windowed brightness dark decision block.
// No dependencies; imported by the controller, the datapath and the top level.
package wbdd_pkg;

   // Width of a brightness value and of the computed mean.
   localparam int MEAN_W = 8;
   // One quotient bit per divider step.
   localparam int DIV_STEPS = MEAN_W;
   localparam int STEP_W = $clog2(DIV_STEPS);

   // Configuration register indexes.
   localparam logic [1:0] REG_DARK_THRESHOLD = 2'd0;
   localparam logic [1:0] REG_HYSTERESIS_BAND = 2'd1;
   localparam logic [1:0] REG_ANALOG_CEILING = 2'd2;
   localparam logic [1:0] REG_DIGITAL_CEILING = 2'd3;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Reset values of the configuration registers.
   localparam logic [7:0] DARK_THRESHOLD_RESET = 8'd65;
   localparam logic [7:0] HYSTERESIS_BAND_RESET = 8'd0;
   localparam logic [7:0] ANALOG_CEILING_RESET = 8'd0;
   localparam logic [15:0] DIGITAL_CEILING_RESET = 16'd0;

   typedef struct packed {
      logic [7:0] dark_threshold;
      logic [7:0] hysteresis_band;
      logic [7:0] analog_ceiling;
      logic [15:0] digital_ceiling;
   } wbdd_cfg_type;

   // Commands from the controller to the datapath; at most one is high.
   typedef struct packed {
      logic accum;
      logic div_load;
      logic div_step;
      logic finish;
   } wbdd_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic last_sample;
      logic div_last;
      logic out_free;
   } wbdd_status_type;

endpackage

>>> design/wbdd_ctrl.sv
`timescale 1ns / 1ps
// Controller of the windowed brightness dark decision block.
// Depends on wbdd_pkg for the command and status structs.
module wbdd_ctrl import wbdd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  wbdd_status_type status,
   output wbdd_cmd_type    cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_LOAD = 2'd1;
   localparam logic [1:0] S_DIV = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accum = 1'b1;
               if (status.last_sample) begin
                  state_in = S_LOAD;
               end
            end
         end
         S_LOAD: begin
            cmd.div_load = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> design/wbdd_dpath.sv
`timescale 1ns / 1ps
// Datapath of the windowed brightness dark decision block: window statistics,
// bit-serial mean divider, decision logic and the result register. Uses wbdd_pkg.
module wbdd_dpath import wbdd_pkg::*; #(
   parameter int WINDOW_LENGTH = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  wbdd_cmd_type    cmd,
   output wbdd_status_type status,
   input  wbdd_cfg_type    cfg,
   input  logic            in_read_ok,
   input  logic [7:0]      in_bright_mean,
   input  logic [7:0]      in_ana_gain,
   input  logic [15:0]     in_digital_gain,
   input  logic            in_exposure_settled,
   input  logic            rsp_stall,
   output logic            rsp_valid,
   output logic            rsp_decided,
   output logic            rsp_is_dark,
   output logic            rsp_decision_changed,
   output logic [7:0]      rsp_window_mean,
   output logic [7:0]      rsp_window_min,
   output logic [7:0]      rsp_window_max,
   output logic [4:0]      rsp_valid_count,
   output logic            rsp_gains_railed,
   output logic            rsp_last_settled,
   output logic [7:0]      rsp_last_analog
);

   localparam int IDX_W = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
   localparam int CNT_W = $clog2(WINDOW_LENGTH + 1);
   localparam int SUM_W = CNT_W + MEAN_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_LENGTH - 1);

   // Window statistics.
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  good_ff, good_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [7:0]        low_ff, low_in;
   logic [7:0]        high_ff, high_in;
   logic [CNT_W-1:0]  railed_ff, railed_in;
   logic              settled_ff, settled_in;
   logic [7:0]        analog_ff, analog_in;
   logic              dark_ff, dark_in;

   // Divider.
   logic [SUM_W-1:0]  rem_ff, rem_in;
   logic [SUM_W-1:0]  dvs_ff, dvs_in;
   logic [MEAN_W-1:0] quo_ff, quo_in;
   logic [STEP_W-1:0] step_ff, step_in;

   // Result register.
   logic              out_valid_ff, out_valid_in;
   logic              out_decided_ff, out_dark_ff, out_changed_ff;
   logic [7:0]        out_mean_ff, out_min_ff, out_max_ff, out_analog_ff;
   logic [4:0]        out_count_ff;
   logic              out_railed_ff, out_settled_ff;

   logic              railed_hit;
   logic              decided;
   logic              railed_major;
   logic [8:0]        bright_limit;
   logic              dark_next;
   logic [CNT_W+4:0]  count_ext;

   assign railed_hit = (cfg.analog_ceiling != 8'd0) && (in_ana_gain >= cfg.analog_ceiling)
                    && (cfg.digital_ceiling != 16'd0)
                    && (in_digital_gain >= cfg.digital_ceiling);

   assign decided = (good_ff != '0);
   assign railed_major = {railed_ff, 1'b0} > {1'b0, good_ff};
   assign bright_limit = {1'b0, cfg.dark_threshold} + {1'b0, cfg.hysteresis_band};
   assign count_ext = (CNT_W + 5)'(good_ff);

   always_comb begin
      priority if (!decided) begin
         dark_next = dark_ff;
      end else if (railed_major) begin
         dark_next = 1'b1;
      end else if (quo_ff < cfg.dark_threshold) begin
         dark_next = 1'b1;
      end else if ({1'b0, quo_ff} >= bright_limit) begin
         dark_next = 1'b0;
      end else begin
         dark_next = dark_ff;
      end
   end

   assign status.last_sample = (idx_ff == LAST_IDX);
   assign status.div_last = (step_ff == STEP_W'(DIV_STEPS - 1));
   assign status.out_free = !out_valid_ff || !rsp_stall;

   // Window statistics and the stored decision.
   always_comb begin
      idx_in = idx_ff;
      good_in = good_ff;
      sum_in = sum_ff;
      low_in = low_ff;
      high_in = high_ff;
      railed_in = railed_ff;
      settled_in = settled_ff;
      analog_in = analog_ff;
      dark_in = dark_ff;
      if (cmd.accum) begin
         idx_in = status.last_sample ? '0 : idx_ff + 1'b1;
         if (in_read_ok) begin
            good_in = good_ff + 1'b1;
            sum_in = sum_ff + SUM_W'(in_bright_mean);
            if (in_bright_mean < low_ff) begin
               low_in = in_bright_mean;
            end
            if (in_bright_mean > high_ff) begin
               high_in = in_bright_mean;
            end
            settled_in = in_exposure_settled;
            analog_in = in_ana_gain;
            if (railed_hit) begin
               railed_in = railed_ff + 1'b1;
            end
         end
      end
      if (cmd.finish) begin
         good_in = '0;
         sum_in = '0;
         low_in = 8'hFF;
         high_in = 8'h00;
         railed_in = '0;
         settled_in = 1'b0;
         analog_in = 8'h00;
         dark_in = dark_next;
      end
   end

   // Restoring divider, one quotient bit per step, most significant first.
   always_comb begin
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      quo_in = quo_ff;
      step_in = step_ff;
      if (cmd.div_load) begin
         rem_in = sum_ff;
         dvs_in = SUM_W'({good_ff, {(MEAN_W - 1){1'b0}}});
         quo_in = '0;
         step_in = '0;
      end else if (cmd.div_step) begin
         if (rem_ff >= dvs_ff) begin
            rem_in = rem_ff - dvs_ff;
            quo_in = {quo_ff[MEAN_W-2:0], 1'b1};
         end else begin
            quo_in = {quo_ff[MEAN_W-2:0], 1'b0};
         end
         dvs_in = dvs_ff >> 1;
         step_in = step_ff + 1'b1;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.finish) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         good_ff <= '0;
         sum_ff <= '0;
         low_ff <= 8'hFF;
         high_ff <= 8'h00;
         railed_ff <= '0;
         settled_ff <= 1'b0;
         analog_ff <= 8'h00;
         dark_ff <= 1'b0;
         step_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         good_ff <= good_in;
         sum_ff <= sum_in;
         low_ff <= low_in;
         high_ff <= high_in;
         railed_ff <= railed_in;
         settled_ff <= settled_in;
         analog_ff <= analog_in;
         dark_ff <= dark_in;
         step_ff <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
      if (cmd.finish) begin
         out_decided_ff <= decided;
         out_dark_ff <= dark_next;
         out_changed_ff <= dark_next != dark_ff;
         out_mean_ff <= decided ? quo_ff : 8'h00;
         out_min_ff <= decided ? low_ff : 8'h00;
         out_max_ff <= decided ? high_ff : 8'h00;
         out_count_ff <= count_ext[4:0];
         out_railed_ff <= decided && railed_major;
         out_settled_ff <= decided && settled_ff;
         out_analog_ff <= decided ? analog_ff : 8'h00;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_decided = out_decided_ff;
   assign rsp_is_dark = out_dark_ff;
   assign rsp_decision_changed = out_changed_ff;
   assign rsp_window_mean = out_mean_ff;
   assign rsp_window_min = out_min_ff;
   assign rsp_window_max = out_max_ff;
   assign rsp_valid_count = out_count_ff;
   assign rsp_gains_railed = out_railed_ff;
   assign rsp_last_settled = out_settled_ff;
   assign rsp_last_analog = out_analog_ff;

endmodule

>>> design/windowed_brightness_dark_decision.sv
`timescale 1ns / 1ps
// Top level of the windowed brightness dark decision block: configuration
// registers, controller and datapath. Depends on wbdd_pkg, wbdd_ctrl, wbdd_dpath.
//
// Usage: one auto-exposure sample enters per req_ beat. After WINDOW_LENGTH
// samples the block emits one rsp_ beat with the window's mean, minimum,
// maximum, valid count, railed flag and the dark/bright decision.
// Samples that do not close a window are accepted back to back; req_stall stays low.
// The sample that closes a window is followed by a busy phase with req_stall high:
// the divider is loaded, the bit-serial mean division produces one quotient bit
// per cycle, and a final step forms the decision and loads the result register.
// The result sits in an output register; while rsp_stall holds it, samples
// of the next window are still accepted. Only when a second window finishes
// before the first result is taken does the block wait in its final step.
// Reset (synchronous, active high) clears the window statistics, sets the
// decision to bright and restores the configuration registers to defaults.
// Registers live on the csr_ port at byte addresses 0, 4, 8 and 12; writes
// complete in the APB access cycle and pready is always high.
module windowed_brightness_dark_decision import wbdd_pkg::*; #(
   parameter int WINDOW_LENGTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   // Sample channel.
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_read_ok,
   input  logic [7:0]            req_bright_mean,
   input  logic [7:0]            req_ana_gain,
   input  logic [15:0]           req_digital_gain,
   input  logic                  req_exposure_settled,
   // Result channel.
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_decided,
   output logic                  rsp_is_dark,
   output logic                  rsp_decision_changed,
   output logic [7:0]            rsp_window_mean,
   output logic [7:0]            rsp_window_min,
   output logic [7:0]            rsp_window_max,
   output logic [4:0]            rsp_valid_count,
   output logic                  rsp_gains_railed,
   output logic                  rsp_last_settled,
   output logic [7:0]            rsp_last_analog,
   // Configuration port.
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

`include "windowed_brightness_dark_decision_assert.svh"

   wbdd_cfg_type    cfg_ff, cfg_in;
   wbdd_cmd_type    ctrl_cmd;
   wbdd_status_type dp_status;
   logic            csr_write;
   logic [1:0]      csr_index;
   logic            busy_cmd;
   logic            mean_in_range;
   logic            empty_stats_clear;

   // The register index is the word address; the two low address bits are ignored.
   assign csr_pready = 1'b1;
   assign csr_index = csr_paddr[3:2];
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_DARK_THRESHOLD:  cfg_in.dark_threshold = csr_pwdata[7:0];
            REG_HYSTERESIS_BAND: cfg_in.hysteresis_band = csr_pwdata[7:0];
            REG_ANALOG_CEILING:  cfg_in.analog_ceiling = csr_pwdata[7:0];
            REG_DIGITAL_CEILING: cfg_in.digital_ceiling = csr_pwdata[15:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_DARK_THRESHOLD:  csr_prdata = CSR_DATA_W'(cfg_ff.dark_threshold);
         REG_HYSTERESIS_BAND: csr_prdata = CSR_DATA_W'(cfg_ff.hysteresis_band);
         REG_ANALOG_CEILING:  csr_prdata = CSR_DATA_W'(cfg_ff.analog_ceiling);
         REG_DIGITAL_CEILING: csr_prdata = CSR_DATA_W'(cfg_ff.digital_ceiling);
         default:             csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dark_threshold <= DARK_THRESHOLD_RESET;
         cfg_ff.hysteresis_band <= HYSTERESIS_BAND_RESET;
         cfg_ff.analog_ceiling <= ANALOG_CEILING_RESET;
         cfg_ff.digital_ceiling <= DIGITAL_CEILING_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The controller sequences accumulation, division and result loading.
   wbdd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (dp_status),
      .cmd       (ctrl_cmd)
   );

   // The datapath holds the window statistics, the divider and the result beat.
   wbdd_dpath #(
      .WINDOW_LENGTH (WINDOW_LENGTH)
   ) u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (ctrl_cmd),
      .status               (dp_status),
      .cfg                  (cfg_ff),
      .in_read_ok           (req_read_ok),
      .in_bright_mean       (req_bright_mean),
      .in_ana_gain          (req_ana_gain),
      .in_digital_gain      (req_digital_gain),
      .in_exposure_settled  (req_exposure_settled),
      .rsp_stall            (rsp_stall),
      .rsp_valid            (rsp_valid),
      .rsp_decided          (rsp_decided),
      .rsp_is_dark          (rsp_is_dark),
      .rsp_decision_changed (rsp_decision_changed),
      .rsp_window_mean      (rsp_window_mean),
      .rsp_window_min       (rsp_window_min),
      .rsp_window_max       (rsp_window_max),
      .rsp_valid_count      (rsp_valid_count),
      .rsp_gains_railed     (rsp_gains_railed),
      .rsp_last_settled     (rsp_last_settled),
      .rsp_last_analog      (rsp_last_analog)
   );

   assign busy_cmd = ctrl_cmd.div_step || ctrl_cmd.finish;
   assign mean_in_range = (rsp_window_min <= rsp_window_mean)
                       && (rsp_window_mean <= rsp_window_max);
   assign empty_stats_clear = (rsp_valid_count == 5'd0) && (rsp_window_max == 8'd0)
                           && !rsp_decision_changed;

   // The divider and the result load never run while samples are being taken.
   `WBDD_ASSERT_IMPLY(a_no_accept_while_busy, !req_stall, !busy_cmd)
   // Loading a result always presents a beat in the next cycle.
   `WBDD_ASSERT_NEXT(a_finish_shows_beat, ctrl_cmd.finish, rsp_valid)
   // The mean of a decided window lies between its minimum and maximum.
   `WBDD_ASSERT_IMPLY(a_mean_in_range, rsp_valid && rsp_decided, mean_in_range)
   // An empty window reports zero statistics and no change of decision.
   `WBDD_ASSERT_IMPLY(a_empty_window, rsp_valid && !rsp_decided, empty_stats_clear)

endmodule
